FILE: hw/rtl/char_lcd_two_line_frame_builder_defines.svh
// Assertion macros for the two-line character LCD frame builder.
// Used only by the top level; no other dependencies.
`ifndef CHAR_LCD_TWO_LINE_FRAME_BUILDER_DEFINES_SVH
`define CHAR_LCD_TWO_LINE_FRAME_BUILDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CLCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define CLCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/clcd_pkg.sv
// Shared types, constants and functions of the LCD frame builder.
// No dependencies.
package clcd_pkg;

   localparam logic [7:0] JUMP_LINE_ONE = 8'h80;
   localparam logic [7:0] JUMP_LINE_TWO = 8'hC0;
   localparam logic [7:0] NIBBLE_MASK   = 8'hF0;
   localparam logic [7:0] EN_BIT        = 8'h04;
   localparam logic [7:0] BL_BIT        = 8'h08;
   localparam logic [7:0] RS_BIT        = 8'h01;
   localparam logic [7:0] SPACE_CODE    = 8'h20;

   typedef enum logic {
      ST_IDLE,
      ST_WORK
   } clcd_state_type;

   typedef struct packed {
      logic capture;
      logic emit_jump;
      logic emit_char;
      logic emit_pad;
      logic finish;
   } clcd_cmd_type;

   typedef struct packed {
      logic jump_pending;
      logic char_pending;
      logic pad_pending;
      logic slot_free;
   } clcd_sts_type;

   // Four expander bytes for one LCD write, first byte in the low bits.
   function automatic logic [31:0] make_group(input logic [7:0] word, input logic data);
      logic [7:0] rs;
      logic [7:0] hi;
      logic [7:0] lo;
      rs = data ? RS_BIT : 8'h00;
      hi = word & NIBBLE_MASK;
      lo = {word[3:0], 4'h0};
      make_group = {lo | rs | BL_BIT,
                    lo | rs | EN_BIT | BL_BIT,
                    hi | rs | BL_BIT,
                    hi | rs | EN_BIT | BL_BIT};
   endfunction

endpackage

FILE: hw/rtl/char_lcd_two_line_frame_builder.sv
// Two-line character LCD frame builder: turns characters into 4-bit expander
// write groups. An item is taken when the block is idle; it then puts out one
// write group per cycle (line jump, character, padding spaces) through a single
// output register while rsp_tready does not hold it, and takes the next item only
// once all write groups of the last are issued. A line opens with its jump command,
// characters past LINE_WIDTH columns are dropped, end of line pads with spaces, and
// the last write group of an item that ends the second line closes a frame.
`include "char_lcd_two_line_frame_builder_defines.svh"

module char_lcd_two_line_frame_builder import clcd_pkg::*; #(
   parameter int LINE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tuser,   // [0] char_valid
   input  logic        req_tlast,   // end_of_line
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] byte_first, [15:8] byte_second, [23:16] byte_third, [31:24] byte_fourth
   output logic [31:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [0] is_command, [1] last_of_item
   output logic        rsp_tlast    // last_of_frame
);

   localparam int COL_W = $clog2(LINE_WIDTH + 1);

   clcd_cmd_type cmd;
   clcd_sts_type sts;

   clcd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   clcd_dp #(
      .LINE_WIDTH (LINE_WIDTH),
      .COL_W      (COL_W)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   `CLCD_ASSERT_NEXT(a_one_item_at_a_time, clock, reset, req_tvalid && req_tready, !req_tready, "item accepted while busy")
   `CLCD_ASSERT_NOW(a_frame_ends_item, clock, reset, rsp_tvalid && rsp_tlast, rsp_tuser[1], "frame end not at item end")
   `CLCD_ASSERT_NOW(a_single_emit, clock, reset, 1'b1, $onehot0({cmd.emit_jump, cmd.emit_char, cmd.emit_pad}), "more than one write at once")
   `CLCD_ASSERT_NOW(a_jump_code, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata[7:4] == 4'h8 || rsp_tdata[7:4] == 4'hC, "bad jump command")

endmodule

FILE: hw/rtl/clcd_ctrl.sv
// Controller of the LCD frame builder: sequences jump, character and padding writes.
// Depends on clcd_pkg.
module clcd_ctrl import clcd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  clcd_sts_type sts,
   output clcd_cmd_type cmd
);

   clcd_state_type state_ff;
   clcd_state_type state_in;
   logic           busy;

   assign busy = sts.jump_pending | sts.char_pending | sts.pad_pending;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_WORK;
         end
         ST_WORK: begin
            if (!busy) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_WORK: begin
            // one write group per free output slot, in line order
            if (sts.slot_free) begin
               if (sts.jump_pending)      cmd.emit_jump = 1'b1;
               else if (sts.char_pending) cmd.emit_char = 1'b1;
               else if (sts.pad_pending)  cmd.emit_pad  = 1'b1;
            end
            cmd.finish = !busy;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

FILE: hw/rtl/clcd_dp.sv
// Datapath of the LCD frame builder: line state, held item and output register.
// Depends on clcd_pkg.
module clcd_dp import clcd_pkg::*; #(
   parameter int LINE_WIDTH = 16,
   parameter int COL_W      = 5
) (
   input  logic         clock,
   input  logic         reset,
   input  clcd_cmd_type cmd,
   output clcd_sts_type sts,
   input  logic [7:0]   req_tdata,
   input  logic         req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   localparam logic [COL_W-1:0] WIDTH_C = COL_W'(LINE_WIDTH);

   logic             line_ff, line_in;
   logic             jump_ff, jump_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [7:0]       code_ff, code_in;
   logic             chr_ff, chr_in;
   logic             eol_ff, eol_in;
   logic             out_valid_ff, out_valid_in;
   logic [31:0]      out_data_ff, out_data_in;
   logic             out_cmd_ff, out_cmd_in;
   logic             out_item_ff, out_item_in;
   logic             out_frame_ff, out_frame_in;

   logic [COL_W-1:0] col_inc;
   logic             room;
   logic             room_after;
   logic [7:0]       word;
   logic             more;
   logic             any_emit;

   assign col_inc    = col_ff + COL_W'(1);
   assign room       = col_ff < WIDTH_C;
   assign room_after = col_inc < WIDTH_C;
   assign any_emit   = cmd.emit_jump | cmd.emit_char | cmd.emit_pad;

   assign sts.jump_pending = !jump_ff;
   assign sts.char_pending = chr_ff & room;
   assign sts.pad_pending  = eol_ff & room;
   assign sts.slot_free    = !out_valid_ff | rsp_tready;

   // pick the write word and whether more writes follow for this item
   always_comb begin
      word = SPACE_CODE;
      more = room_after;
      if (cmd.emit_jump) begin
         word = line_ff ? JUMP_LINE_TWO : JUMP_LINE_ONE;
         more = sts.char_pending | sts.pad_pending;
      end else if (cmd.emit_char) begin
         word = code_ff;
         more = eol_ff & room_after;
      end
   end

   always_comb begin
      line_in      = line_ff;
      jump_in      = jump_ff;
      col_in       = col_ff;
      code_in      = code_ff;
      chr_in       = chr_ff;
      eol_in       = eol_ff;
      out_valid_in = out_valid_ff & !rsp_tready;
      out_data_in  = out_data_ff;
      out_cmd_in   = out_cmd_ff;
      out_item_in  = out_item_ff;
      out_frame_in = out_frame_ff;

      if (cmd.capture) begin
         code_in = req_tdata;
         chr_in  = req_tuser;
         eol_in  = req_tlast;
      end
      if (any_emit) begin
         out_valid_in = 1'b1;
         out_data_in  = make_group(word, !cmd.emit_jump);
         out_cmd_in   = cmd.emit_jump;
         out_item_in  = !more;
         out_frame_in = !more & eol_ff & line_ff;
      end
      if (cmd.emit_jump) jump_in = 1'b1;
      if (cmd.emit_char) begin
         chr_in = 1'b0;
         col_in = col_inc;
      end
      if (cmd.emit_pad) col_in = col_inc;
      // close the line once all its writes are out
      if (cmd.finish && eol_ff) begin
         line_in = !line_ff;
         col_in  = '0;
         jump_in = 1'b0;
         eol_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff      <= 1'b0;
         jump_ff      <= 1'b0;
         col_ff       <= '0;
         chr_ff       <= 1'b0;
         eol_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         line_ff      <= line_in;
         jump_ff      <= jump_in;
         col_ff       <= col_in;
         chr_ff       <= chr_in;
         eol_ff       <= eol_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      out_data_ff  <= out_data_in;
      out_cmd_ff   <= out_cmd_in;
      out_item_ff  <= out_item_in;
      out_frame_ff <= out_frame_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = {out_item_ff, out_cmd_ff};
   assign rsp_tlast  = out_frame_ff;

endmodule

FILE: tb/sv/char_lcd_two_line_frame_builder_test.sv
// Self-checking testbench for the two-line character LCD frame builder.
// Predicts the expander write groups per character item and checks them in order.
// Depends on clcd_pkg and the char_lcd_two_line_frame_builder RTL.
module char_lcd_two_line_frame_builder_test;
   import clcd_pkg::*;

   localparam int LINE_COLS = 16;

   typedef struct packed {
      logic [7:0] byte_first;
      logic [7:0] byte_second;
      logic [7:0] byte_third;
      logic [7:0] byte_fourth;
      logic       is_command;
      logic       last_of_item;
      logic       last_of_frame;
   } lcd_write_type;

   class lcd_write_scoreboard;
      lcd_write_type pending_writes[$];
      bit            on_second_line;
      int unsigned   cols_used;
      bit            line_opened;
      int unsigned   mismatches;

      function new();
         on_second_line = 1'b0;
         cols_used      = 0;
         line_opened    = 1'b0;
         mismatches     = 0;
      endfunction

      function int pending();
         return pending_writes.size();
      endfunction

      // One LCD write as four expander bytes: high nibble first, enable pulsed.
      function lcd_write_type build_write(input logic [7:0] word, input bit is_data);
         lcd_write_type w;
         logic [7:0] flags;
         flags           = BL_BIT | (is_data ? RS_BIT : 8'h00);
         w.byte_first    = {word[7:4], 4'h0} | flags | EN_BIT;
         w.byte_second   = {word[7:4], 4'h0} | flags;
         w.byte_third    = {word[3:0], 4'h0} | flags | EN_BIT;
         w.byte_fourth   = {word[3:0], 4'h0} | flags;
         w.is_command    = !is_data;
         w.last_of_item  = 1'b0;
         w.last_of_frame = 1'b0;
         return w;
      endfunction

      function void note_item(input logic [7:0] code, input bit valid, input bit eol);
         lcd_write_type writes[$];
         if (!line_opened) begin
            writes.push_back(build_write(on_second_line ? JUMP_LINE_TWO : JUMP_LINE_ONE, 1'b0));
            line_opened = 1'b1;
         end
         if (valid && cols_used < LINE_COLS) begin
            writes.push_back(build_write(code, 1'b1));
            cols_used++;
         end
         if (eol) begin
            while (cols_used < LINE_COLS) begin
               writes.push_back(build_write(SPACE_CODE, 1'b1));
               cols_used++;
            end
            // a full second line closed by a bare end mark carries no frame flag
            if (on_second_line && writes.size() > 0)
               writes[writes.size() - 1].last_of_frame = 1'b1;
            on_second_line = !on_second_line;
            cols_used      = 0;
            line_opened    = 1'b0;
         end
         if (writes.size() > 0)
            writes[writes.size() - 1].last_of_item = 1'b1;
         foreach (writes[i])
            pending_writes.push_back(writes[i]);
      endfunction

      function void compare_field(input string name, input logic [7:0] want,
                                  input logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(input logic [31:0] data, input logic [1:0] user,
                                 input logic last);
         lcd_write_type want;
         if (pending_writes.size() == 0) begin
            $display("%0t: write group with none expected, expected nothing actual %h %b %b",
                     $time, data, user, last);
            mismatches++;
            return;
         end
         want = pending_writes.pop_front();
         compare_field("byte_first", want.byte_first, data[7:0]);
         compare_field("byte_second", want.byte_second, data[15:8]);
         compare_field("byte_third", want.byte_third, data[23:16]);
         compare_field("byte_fourth", want.byte_fourth, data[31:24]);
         compare_field("is_command", 8'(want.is_command), 8'(user[0]));
         compare_field("last_of_item", 8'(want.last_of_item), 8'(user[1]));
         compare_field("last_of_frame", 8'(want.last_of_frame), 8'(last));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   lcd_write_scoreboard lcd_sb;
   bit          quiet_tail = 1'b0;
   int unsigned stall_left = 0;
   int unsigned items_sent = 0;

   char_lcd_two_line_frame_builder #(.LINE_WIDTH(LINE_COLS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Check accepted write groups and stall the result side in short bursts.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         lcd_sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 6);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(input logic [7:0] code, input bit valid, input bit eol);
      int gap;
      gap = 0;
      if (!quiet_tail && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= code;
      req_tuser  <= valid;
      req_tlast  <= eol;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      lcd_sb.note_item(code, valid, eol);
      items_sent++;
   endtask

   // Hold the sender until every predicted write group has arrived.
   task automatic drain_writes();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (lcd_sb.pending() != 0) @(posedge clock);
   endtask

   task automatic send_random_line();
      int line_len;
      if ($urandom_range(0, 7) == 0)
         line_len = $urandom_range(LINE_COLS - 1, LINE_COLS + 4);
      else
         line_len = $urandom_range(0, LINE_COLS - 2);
      for (int k = 0; k < line_len; k++)
         send_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0, 1'b0);
      send_item(8'($urandom_range(0, 255)), $urandom_range(0, 1) == 1, 1'b1);
   endtask

   initial begin
      lcd_sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // first line: open with a bare item, nibble extremes, ignored code, end with char
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h00, 1'b1, 1'b0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'hA5, 1'b0, 1'b0);
      send_item(8'h5A, 1'b1, 1'b1);
      // second line: bare end mark gives jump plus a full row of spaces
      send_item(8'h3C, 1'b0, 1'b1);
      // first line filled, overflow char dropped, end mark with no room left
      for (int i = 0; i < LINE_COLS; i++)
         send_item(8'(i * 17), 1'b1, 1'b0);
      send_item(8'hC3, 1'b1, 1'b0);
      send_item(8'h7E, 1'b0, 1'b1);
      // second line opened, filled and ended by one item
      send_item(8'h81, 1'b1, 1'b1);
      drain_writes();

      while (items_sent < 450) begin
         if ($urandom_range(0, 9) == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 3) == 0);
         else
            send_random_line();
         if (items_sent >= 200 && items_sent < 215)
            drain_writes();
         if (items_sent >= 400)
            quiet_tail = 1'b1;
      end
      drain_writes();
      repeat (LINE_COLS + 8) @(posedge clock);

      if (lcd_sb.pending() != 0)
         $display("%0t: %0d write groups expected but never seen", $time, lcd_sb.pending());
      if (lcd_sb.mismatches == 0 && lcd_sb.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("%0t: timeout", $time);
      $display("Mismatches found");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/clcd_pkg.sv
hw/rtl/clcd_ctrl.sv
hw/rtl/clcd_dp.sv
hw/rtl/char_lcd_two_line_frame_builder.sv
tb/sv/char_lcd_two_line_frame_builder_test.sv
